/* rtl/mips_pkg.sv */
// shared types and constants for the maximum inner product search core
// no dependencies

package mips_pkg;

   localparam int SUM_W           = 38;
   localparam int INDEX_W         = 11;
   localparam int POS_W           = 6;
   localparam int CSR_DATA_W      = 11;
   localparam int DIMS_REG_W      = 7;
   localparam int COUNT_REG_W     = 11;
   localparam int DIMS_RESET_VAL  = 64;
   localparam int COUNT_RESET_VAL = 1024;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = 2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DATA = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_DIMS  = 1'b0,
      CSR_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic end_vec;
      logic first_vec;
      logic end_search;
   } mac_tag_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/mips_queue.sv */
// short fifo between the front and back parts of the search core
// depends on mips_pkg

module mips_queue
   import mips_pkg::*;
#(
   parameter int WIDTH = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* rtl/mips_front.sv */
// front part: takes request beats, sorts query loads from data elements
// and drops loads outside the query store; depends on mips_pkg

module mips_front
   import mips_pkg::*;
#(
   parameter int MAX_DIMS      = 64,
   parameter int ELEMENT_WIDTH = 16,
   parameter int AW            = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [POS_W-1:0]                req_query_position,
   input  logic signed [ELEMENT_WIDTH-1:0] req_element_value,
   input  queue_status_type                q_status,
   output logic                            push,
   output logic [AW+ELEMENT_WIDTH:0]       push_data
);

   logic                        valid_ff, valid_in;
   logic                        is_data_ff;
   logic [AW-1:0]               pos_ff;
   logic [ELEMENT_WIDTH-1:0]    value_ff;
   logic                        accept;
   logic                        is_data;
   logic                        drop;

   assign is_data   = (req_command == CMD_DATA);
   assign drop      = !is_data && (int'(req_query_position) >= MAX_DIMS);
   assign push      = valid_ff && !q_status.full;
   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = !drop;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_data_ff <= is_data;
         pos_ff     <= AW'(req_query_position);
         value_ff   <= req_element_value;
      end
   end

   assign push_data = {is_data_ff, pos_ff, value_ff};

endmodule

/* rtl/mips_back.sv */
// back part: query store, element and vector counters, multiply-accumulate
// pipeline, best tracking and result register; depends on mips_pkg

module mips_back
   import mips_pkg::*;
#(
   parameter int MAX_DIMS      = 64,
   parameter int MAX_VECTORS   = 1024,
   parameter int ELEMENT_WIDTH = 16,
   parameter int AW            = 6,
   parameter int DW            = 7,
   parameter int VW            = 10,
   parameter int VLW           = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [AW+ELEMENT_WIDTH:0]       pop_data,
   input  queue_status_type                q_status,
   output logic                            pop,
   input  logic [DW-1:0]                   dims_lim,
   input  logic [VLW-1:0]                  count_lim,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [INDEX_W-1:0]              rsp_best_index,
   output logic signed [SUM_W-1:0]         rsp_best_product
);

   localparam int EW = ELEMENT_WIDTH;
   localparam int PW = 2 * EW;
   localparam int XW = ((PW > SUM_W) ? PW : SUM_W) + 1;

   logic                 adv;
   logic                 take;
   logic                 in_is_data;
   logic [AW-1:0]        in_pos;
   logic signed [EW-1:0] in_value;

   logic signed [EW-1:0] store_mem [MAX_DIMS];

   logic [AW-1:0]  elem_cnt_ff, elem_cnt_in;
   logic [VW-1:0]  vec_cnt_ff, vec_cnt_in;
   logic [DW:0]    elem_next;
   logic [VLW:0]   vec_next;
   logic           end_vec;
   logic           last_vec;

   logic                 s1_valid_ff;
   mac_tag_type          s1_tag_ff;
   logic [VW-1:0]        s1_vidx_ff;
   logic signed [EW-1:0] s1_elem_ff;
   logic signed [EW-1:0] s1_q_ff;

   logic                 s2_valid_ff;
   mac_tag_type          s2_tag_ff;
   logic [VW-1:0]        s2_vidx_ff;
   logic signed [PW-1:0] s2_prod_ff;

   logic                    s3_valid_ff;
   mac_tag_type             s3_tag_ff;
   logic [VW-1:0]           s3_vidx_ff;
   logic signed [SUM_W-1:0] s3_prod_ff, s3_prod_in;
   logic signed [XW-1:0]    prod_x;

   logic signed [SUM_W-1:0] run_ff, run_in;
   logic signed [SUM_W:0]   acc_x;
   logic signed [SUM_W-1:0] acc_sat;

   logic                    s4_valid_ff;
   mac_tag_type             s4_tag_ff;
   logic [VW-1:0]           s4_vidx_ff;
   logic signed [SUM_W-1:0] s4_sum_ff;

   logic signed [SUM_W-1:0] best_ff, best_in;
   logic [VW-1:0]           best_pos_ff, best_pos_in;
   logic signed [SUM_W-1:0] new_best;
   logic [VW-1:0]           new_pos;
   logic [VW:0]             pos_p1;

   logic                    rsp_valid_ff;
   logic [INDEX_W-1:0]      rsp_index_ff;
   logic signed [SUM_W-1:0] rsp_product_ff;

   assign adv  = !rsp_valid_ff || !rsp_stall;
   assign pop  = adv && !q_status.empty;

   assign in_is_data = pop_data[AW+EW];
   assign in_pos     = pop_data[AW+EW-1:EW];
   assign in_value   = pop_data[EW-1:0];
   assign take       = pop && in_is_data;

   // query store
   always_ff @(posedge clock) begin
      if (pop && !in_is_data) begin
         store_mem[in_pos] <= in_value;
      end
      if (adv) begin
         s1_q_ff <= store_mem[elem_cnt_ff];
      end
   end

   // element and vector counting
   always_comb begin
      elem_next   = (DW+1)'(elem_cnt_ff) + 1'b1;
      vec_next    = (VLW+1)'(vec_cnt_ff) + 1'b1;
      end_vec     = (elem_next >= (DW+1)'(dims_lim));
      last_vec    = (vec_next >= (VLW+1)'(count_lim));
      elem_cnt_in = elem_cnt_ff;
      vec_cnt_in  = vec_cnt_ff;
      if (take) begin
         elem_cnt_in = end_vec ? '0 : AW'(elem_next);
         if (end_vec) begin
            vec_cnt_in = last_vec ? '0 : VW'(vec_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_cnt_ff <= '0;
         vec_cnt_ff  <= '0;
      end else begin
         elem_cnt_ff <= elem_cnt_in;
         vec_cnt_ff  <= vec_cnt_in;
      end
   end

   // product saturation
   always_comb begin
      prod_x = XW'(s2_prod_ff);
      if (prod_x > XW'(SUM_MAX)) begin
         s3_prod_in = SUM_MAX;
      end else if (prod_x < XW'(SUM_MIN)) begin
         s3_prod_in = SUM_MIN;
      end else begin
         s3_prod_in = SUM_W'(prod_x);
      end
   end

   // accumulate with saturation
   always_comb begin
      acc_x = (SUM_W+1)'(run_ff) + (SUM_W+1)'(s3_prod_ff);
      if (acc_x > (SUM_W+1)'(SUM_MAX)) begin
         acc_sat = SUM_MAX;
      end else if (acc_x < (SUM_W+1)'(SUM_MIN)) begin
         acc_sat = SUM_MIN;
      end else begin
         acc_sat = SUM_W'(acc_x);
      end
      run_in = run_ff;
      if (adv && s3_valid_ff) begin
         run_in = s3_tag_ff.end_vec ? '0 : acc_sat;
      end
   end

   // best so far
   always_comb begin
      if (s4_tag_ff.first_vec || (s4_sum_ff > best_ff)) begin
         new_best = s4_sum_ff;
         new_pos  = s4_vidx_ff;
      end else begin
         new_best = best_ff;
         new_pos  = best_pos_ff;
      end
      pos_p1      = {1'b0, new_pos} + 1'b1;
      best_in     = best_ff;
      best_pos_in = best_pos_ff;
      if (adv && s4_valid_ff) begin
         best_in     = s4_tag_ff.end_search ? '0 : new_best;
         best_pos_in = s4_tag_ff.end_search ? '0 : new_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
         best_ff      <= '0;
         best_pos_ff  <= '0;
      end else begin
         run_ff      <= run_in;
         best_ff     <= best_in;
         best_pos_ff <= best_pos_in;
         if (adv) begin
            s1_valid_ff  <= take;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            s4_valid_ff  <= s3_valid_ff && s3_tag_ff.end_vec;
            rsp_valid_ff <= s4_valid_ff && s4_tag_ff.end_search;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff.end_vec    <= end_vec;
         s1_tag_ff.first_vec  <= (vec_cnt_ff == '0);
         s1_tag_ff.end_search <= end_vec && last_vec;
         s1_vidx_ff           <= vec_cnt_ff;
         s1_elem_ff           <= in_value;

         s2_tag_ff  <= s1_tag_ff;
         s2_vidx_ff <= s1_vidx_ff;
         s2_prod_ff <= s1_q_ff * s1_elem_ff;

         s3_tag_ff  <= s2_tag_ff;
         s3_vidx_ff <= s2_vidx_ff;
         s3_prod_ff <= s3_prod_in;

         s4_tag_ff  <= s3_tag_ff;
         s4_vidx_ff <= s3_vidx_ff;
         s4_sum_ff  <= acc_sat;

         if (s4_valid_ff && s4_tag_ff.end_search) begin
            rsp_index_ff   <= INDEX_W'(pos_p1);
            rsp_product_ff <= new_best;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_index   = rsp_index_ff;
   assign rsp_best_product = rsp_product_ff;

endmodule

/* rtl/max_inner_product_search_core.sv */
// Brute-force maximum inner product search. Query beats (command load) write one
// Q8.8 element into the query store; data beats stream vector elements in order and
// are multiplied by the matching query element and summed. After the last element
// of the last vector, one response beat carries the 1-based index of the vector with
// the largest sum (first one wins ties) and that sum in Q22.16, saturated to 38 bits.
// One request beat is taken every cycle unless req_stall holds it off (queue full);
// the response to the last data beat passes the front register, the queue and the
// four-stage multiply-accumulate pipeline. A held response stalls the pipeline, and the
// four-entry queue keeps taking beats until it fills.
// depends on mips_pkg, mips_front, mips_queue, mips_back

module max_inner_product_search_core
   import mips_pkg::*;
#(
   parameter int MAX_DIMS      = 64,
   parameter int MAX_VECTORS   = 1024,
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [POS_W-1:0]                req_query_position,
   input  logic signed [ELEMENT_WIDTH-1:0] req_element_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [INDEX_W-1:0]              rsp_best_index,
   output logic signed [SUM_W-1:0]         rsp_best_product,
   input  logic                            csr_write_enable,
   input  csr_index_type                   csr_index,
   input  logic [CSR_DATA_W-1:0]           csr_write_data
);

   localparam int AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DW  = $clog2(MAX_DIMS + 1);
   localparam int VW  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int VLW = $clog2(MAX_VECTORS + 1);
   localparam int QW  = AW + ELEMENT_WIDTH + 1;
   localparam int DIMS_RST  = (DIMS_RESET_VAL > MAX_DIMS) ? MAX_DIMS : DIMS_RESET_VAL;
   localparam int COUNT_RST = (COUNT_RESET_VAL > MAX_VECTORS) ? MAX_VECTORS : COUNT_RESET_VAL;

   logic [DW-1:0]          dims_lim_ff, dims_lim_in;
   logic [VLW-1:0]         count_lim_ff, count_lim_in;
   logic [DIMS_REG_W-1:0]  dims_raw;
   logic [COUNT_REG_W-1:0] count_raw;
   logic [DW-1:0]          dims_sat;
   logic [VLW-1:0]         count_sat;

   logic                   push;
   logic [QW-1:0]          push_data;
   logic                   pop;
   logic [QW-1:0]          pop_data;
   queue_status_type       q_status;

   // register values clipped to 1..max
   always_comb begin
      dims_raw  = csr_write_data[DIMS_REG_W-1:0];
      count_raw = csr_write_data[COUNT_REG_W-1:0];
      if (dims_raw == '0) begin
         dims_sat = DW'(1);
      end else if (int'(dims_raw) > MAX_DIMS) begin
         dims_sat = DW'(MAX_DIMS);
      end else begin
         dims_sat = DW'(dims_raw);
      end
      if (count_raw == '0) begin
         count_sat = VLW'(1);
      end else if (int'(count_raw) > MAX_VECTORS) begin
         count_sat = VLW'(MAX_VECTORS);
      end else begin
         count_sat = VLW'(count_raw);
      end
      dims_lim_in  = dims_lim_ff;
      count_lim_in = count_lim_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIMS:  dims_lim_in  = dims_sat;
            CSR_COUNT: count_lim_in = count_sat;
            default:   dims_lim_in  = dims_lim_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_lim_ff  <= DW'(DIMS_RST);
         count_lim_ff <= VLW'(COUNT_RST);
      end else begin
         dims_lim_ff  <= dims_lim_in;
         count_lim_ff <= count_lim_in;
      end
   end

   mips_front #(
      .MAX_DIMS      (MAX_DIMS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .AW            (AW)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_query_position (req_query_position),
      .req_element_value  (req_element_value),
      .q_status           (q_status),
      .push               (push),
      .push_data          (push_data)
   );

   mips_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   mips_back #(
      .MAX_DIMS      (MAX_DIMS),
      .MAX_VECTORS   (MAX_VECTORS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .AW            (AW),
      .DW            (DW),
      .VW            (VW),
      .VLW           (VLW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_data         (pop_data),
      .q_status         (q_status),
      .pop              (pop),
      .dims_lim         (dims_lim_ff),
      .count_lim        (count_lim_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_index   (rsp_best_index),
      .rsp_best_product (rsp_best_product)
   );

endmodule

/* rtl/mips_checker.sv */
// port-level checks for the maximum inner product search core, bound to the top
// depends on mips_pkg and max_inner_product_search_core

module mips_checker
   import mips_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [INDEX_W-1:0]      rsp_best_index,
   input logic signed [SUM_W-1:0] rsp_best_product
);

   // a stalled response beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // front register is empty right after reset
   a_no_stall_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled straight after reset");

   // no response straight after reset; it must first pass the queue and pipeline
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
      else $error("response too soon after reset");

   // payload of a stalled beat holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_best_index) && $stable(rsp_best_product))
      else $error("stalled response payload changed");

endmodule

bind max_inner_product_search_core mips_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_best_index   (rsp_best_index),
   .rsp_best_product (rsp_best_product)
);

/* bench/mips_search_checker.sv */
// scoreboard for max_inner_product_search_core: keeps its own query store, register copies
// and search state, predicts every result beat and compares it with the response port
// depends on mips_pkg
`timescale 1ns / 1ps

module mips_search_checker
   import mips_pkg::*;
#(
   parameter int MAX_DIMS      = 64,
   parameter int MAX_VECTORS   = 1024,
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_command,
   input  logic [POS_W-1:0]                req_query_position,
   input  logic signed [ELEMENT_WIDTH-1:0] req_element_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [INDEX_W-1:0]              rsp_best_index,
   input  logic signed [SUM_W-1:0]         rsp_best_product,
   input  logic                            csr_write_enable,
   input  csr_index_type                   csr_index,
   input  logic [CSR_DATA_W-1:0]           csr_write_data,
   output int                              failures,
   output int                              outstanding,
   output int                              searches_done
);

   typedef struct {
      logic [INDEX_W-1:0]      index;
      logic signed [SUM_W-1:0] product;
   } search_outcome_type;

   logic signed [ELEMENT_WIDTH-1:0] query_copy [MAX_DIMS];
   logic signed [SUM_W-1:0]         dot_sum;
   logic signed [SUM_W-1:0]         leader_sum;
   int unsigned                     element_index;
   int unsigned                     vector_index;
   int unsigned                     leader_index;
   logic [DIMS_REG_W-1:0]           dims_setting;
   logic [COUNT_REG_W-1:0]          count_setting;
   search_outcome_type              awaited [$];
   int                              mismatch_total = 0;
   int                              search_total = 0;

   function automatic int unsigned clip_size(int unsigned raw, int unsigned ceiling);
      if (raw == 0) return 1;
      if (raw > ceiling) return ceiling;
      return raw;
   endfunction

   function automatic logic signed [SUM_W-1:0] saturate_sum(longint raw);
      if (raw > longint'(SUM_MAX)) return SUM_MAX;
      if (raw < longint'(SUM_MIN)) return SUM_MIN;
      return SUM_W'(raw);
   endfunction

   // one data beat: multiply-accumulate, close the vector and the search when due
   function void fold_data_beat(logic signed [ELEMENT_WIDTH-1:0] value);
      longint             query_term;
      int unsigned        dims_now;
      int unsigned        count_now;
      search_outcome_type found;
      dims_now   = clip_size(32'(dims_setting), MAX_DIMS);
      count_now  = clip_size(32'(count_setting), MAX_VECTORS);
      query_term = (element_index < MAX_DIMS) ? longint'(query_copy[element_index]) : 0;
      dot_sum    = saturate_sum(longint'(dot_sum)
                   + longint'(saturate_sum(query_term * longint'(value))));
      element_index++;
      if (element_index >= dims_now) begin
         // strictly larger replaces, so the earliest vector keeps a tie
         if (vector_index == 0 || dot_sum > leader_sum) begin
            leader_sum   = dot_sum;
            leader_index = vector_index;
         end
         dot_sum       = '0;
         element_index = 0;
         vector_index++;
         if (vector_index >= count_now) begin
            found.index   = INDEX_W'(leader_index + 1);
            found.product = leader_sum;
            awaited.push_back(found);
            search_total++;
            vector_index = 0;
            leader_sum   = '0;
            leader_index = 0;
         end
      end
   endfunction

   always @(posedge clock) begin
      search_outcome_type arrived;
      if (reset) begin
         dot_sum       = '0;
         leader_sum    = '0;
         element_index = 0;
         vector_index  = 0;
         leader_index  = 0;
         dims_setting  = DIMS_REG_W'(DIMS_RESET_VAL);
         count_setting = COUNT_REG_W'(COUNT_RESET_VAL);
         for (int i = 0; i < MAX_DIMS; i++) query_copy[i] = '0;
         awaited.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: unexpected result beat: best_index %0d best_product %0d",
                           $time, rsp_best_index, rsp_best_product);
            end else begin
               arrived = awaited.pop_front();
               if (arrived.index !== rsp_best_index || arrived.product !== rsp_best_product) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("%0t: expected best_index %0d best_product %0d",
                              $time, arrived.index, arrived.product);
                     $display("   got best_index %0d best_product %0d",
                              rsp_best_index, rsp_best_product);
                  end
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DIMS:  dims_setting  = csr_write_data[DIMS_REG_W-1:0];
               CSR_COUNT: count_setting = csr_write_data[COUNT_REG_W-1:0];
               default:   ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (cmd_type'(req_command) == CMD_DATA) begin
               fold_data_beat(req_element_value);
            end else if (int'(req_query_position) < MAX_DIMS) begin
               query_copy[req_query_position] = req_element_value;
            end
         end
      end
      failures      <= mismatch_total;
      outstanding   <= awaited.size();
      searches_done <= search_total;
   end

endmodule

/* bench/tb_top.sv */
// top of the search core testbench: clock, reset, request and register stimulus,
// response stalls, one long response hold-off and the final verdict
// depends on mips_pkg, mips_search_checker and max_inner_product_search_core
`timescale 1ns / 1ps

module tb_top;
   import mips_pkg::*;

   localparam int MAX_DIMS        = 64;
   localparam int MAX_VECTORS     = 1024;
   localparam int ELEMENT_WIDTH   = 16;
   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_BEATS    = 560;
   localparam int QUIET_BEATS     = 80;
   localparam int LONG_VECTORS    = 40;
   localparam int TIMEOUT_NS      = 1_000_000;

   typedef logic signed [ELEMENT_WIDTH-1:0] element_type;
   typedef enum {VALUES_WIDE, VALUES_COARSE, VALUES_EDGE} value_mix_type;

   localparam element_type ELEM_MAX = 16'sh7FFF;
   localparam element_type ELEM_MIN = 16'sh8000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_command;
   logic [POS_W-1:0]        req_query_position;
   element_type             req_element_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [INDEX_W-1:0]      rsp_best_index;
   logic signed [SUM_W-1:0] rsp_best_product;
   logic                    csr_write_enable;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;

   int          failures;
   int          outstanding;
   int          searches_done;
   int unsigned beats_sent = 0;
   int unsigned loads_sent = 0;
   int unsigned phase_total = 0;
   int unsigned gap_odds = 4;
   bit          quiet_tail = 1'b0;
   bit          squeeze_request = 1'b0;
   bit          squeeze_done = 1'b0;

   always #2 clock = ~clock;

   max_inner_product_search_core #(
      .MAX_DIMS      (MAX_DIMS),
      .MAX_VECTORS   (MAX_VECTORS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_query_position (req_query_position),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_best_index     (rsp_best_index),
      .rsp_best_product   (rsp_best_product),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   mips_search_checker #(
      .MAX_DIMS      (MAX_DIMS),
      .MAX_VECTORS   (MAX_VECTORS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) scoreboard (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_query_position (req_query_position),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_best_index     (rsp_best_index),
      .rsp_best_product   (rsp_best_product),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .failures           (failures),
      .outstanding        (outstanding),
      .searches_done      (searches_done)
   );

   function automatic int unsigned clip_size(int unsigned raw, int unsigned ceiling);
      if (raw == 0) return 1;
      if (raw > ceiling) return ceiling;
      return raw;
   endfunction

   function automatic element_type pick_value(value_mix_type mix);
      case (mix)
         VALUES_COARSE: return element_type'((int'($urandom_range(0, 2)) - 1) * 256);
         VALUES_EDGE: begin
            case ($urandom_range(0, 4))
               0:       return ELEM_MIN;
               1:       return ELEM_MAX;
               2:       return '0;
               3:       return element_type'(-1);
               default: return element_type'(1);
            endcase
         end
         default:       return element_type'($urandom);
      endcase
   endfunction

   task automatic offer_beat(cmd_type command, logic [POS_W-1:0] position,
                             element_type value);
      if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= command;
      req_query_position <= position;
      req_element_value  <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (command == CMD_LOAD) loads_sent++;
   endtask

   task automatic offer_element(element_type value);
      offer_beat(CMD_DATA, POS_W'($urandom), value);
   endtask

   // registers change only once the pipeline has drained
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_search_size(logic [CSR_DATA_W-1:0] dims_word,
                                      logic [CSR_DATA_W-1:0] count_word);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DIMS;
      csr_write_data   <= dims_word;
      @(posedge clock);
      csr_index        <= CSR_COUNT;
      csr_write_data   <= count_word;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic stream_search(int unsigned dims_eff, int unsigned count_eff,
                                value_mix_type mix, int unsigned load_odds);
      for (int v = 0; v < count_eff; v++) begin
         for (int e = 0; e < dims_eff; e++) begin
            if (load_odds != 0 && $urandom_range(1, load_odds) == 1)
               offer_beat(CMD_LOAD, POS_W'($urandom), element_type'($urandom));
            offer_element(pick_value(mix));
         end
      end
   endtask

   initial begin : response_side
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_request && !squeeze_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            squeeze_done = 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(30, 120)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      element_type           value;
      logic [CSR_DATA_W-1:0] dims_word;
      logic [CSR_DATA_W-1:0] count_word;
      int unsigned           random_first;
      int unsigned           dims_eff;
      int unsigned           count_eff;
      int unsigned           pick;
      int unsigned           searches;
      int unsigned           spare;
      int unsigned           guard;

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = CMD_LOAD;
      req_query_position = '0;
      req_element_value  = '0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_DIMS;
      csr_write_data     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // whole query store written before any data beat reads it
      for (int p = 0; p < MAX_DIMS; p++) begin
         if (p == 0) value = ELEM_MAX;
         else if (p == 1) value = ELEM_MIN;
         else if (p == 2) value = element_type'(256);
         else value = element_type'($urandom);
         offer_beat(CMD_LOAD, POS_W'(p), value);
      end

      // negative first vector, a tie, a load during the search
      quiesce();
      program_search_size(CSR_DATA_W'(2), CSR_DATA_W'(3));
      offer_element(ELEM_MIN);
      offer_element(ELEM_MAX);
      offer_element(ELEM_MIN);
      offer_element(ELEM_MAX);
      offer_beat(CMD_LOAD, POS_W'(40), element_type'(-1));
      offer_element(ELEM_MIN);
      offer_element(ELEM_MIN);

      // overwrite a query entry in use mid-vector
      quiesce();
      program_search_size(CSR_DATA_W'(3), CSR_DATA_W'(2));
      offer_element(ELEM_MAX);
      offer_element(ELEM_MIN);
      offer_element(ELEM_MAX);
      offer_element(ELEM_MAX);
      offer_beat(CMD_LOAD, POS_W'(1), ELEM_MAX);
      offer_element(ELEM_MAX);
      offer_element('0);

      // zero registers act as one: every data beat is a whole search
      quiesce();
      program_search_size('0, '0);
      offer_element(ELEM_MIN);
      offer_element(ELEM_MAX);
      offer_element('0);

      // sizes shrunk part way through a vector and a search
      quiesce();
      program_search_size(CSR_DATA_W'(8), CSR_DATA_W'(4));
      repeat (19) offer_element(pick_value(VALUES_WIDE));
      quiesce();
      program_search_size(CSR_DATA_W'(2), CSR_DATA_W'(4));
      offer_element(pick_value(VALUES_WIDE));
      quiesce();
      program_search_size(CSR_DATA_W'(2), CSR_DATA_W'(1));
      offer_element(pick_value(VALUES_WIDE));
      offer_element(pick_value(VALUES_WIDE));

      // oversized dims saturate to the full store
      quiesce();
      program_search_size(11'h7FF, CSR_DATA_W'(1));
      stream_search(MAX_DIMS, 1, VALUES_EDGE, 0);

      // upper data bits ignored for dims, oversized count keeps the search open,
      // then a count of one closes it on the next vector
      quiesce();
      program_search_size(11'h780, 11'h7FF);
      stream_search(1, LONG_VECTORS, VALUES_COARSE, 0);
      quiesce();
      program_search_size(CSR_DATA_W'(1), CSR_DATA_W'(1));
      offer_element(pick_value(VALUES_COARSE));

      // long response hold-off with the sender still pushing
      quiesce();
      program_search_size(CSR_DATA_W'(1), CSR_DATA_W'(1));
      gap_odds = 0;
      squeeze_request = 1'b1;
      repeat (60) offer_element(pick_value(VALUES_WIDE));
      while (!squeeze_done) @(posedge clock);

      random_first = beats_sent;
      while (beats_sent - random_first < RANDOM_BEATS) begin
         if (beats_sent - random_first + QUIET_BEATS >= RANDOM_BEATS) quiet_tail = 1'b1;
         pick = $urandom_range(0, 19);
         if (pick == 0) dims_word = '0;
         else if (pick == 1) dims_word = CSR_DATA_W'($urandom_range(65, 127));
         else if (pick == 2) dims_word = CSR_DATA_W'($urandom_range(9, 64));
         else dims_word = CSR_DATA_W'($urandom_range(1, 8));
         dims_word[CSR_DATA_W-1:DIMS_REG_W] = (CSR_DATA_W-DIMS_REG_W)'($urandom);
         dims_eff = clip_size(32'(dims_word[DIMS_REG_W-1:0]), MAX_DIMS);
         if ($urandom_range(0, 9) == 0) count_word = '0;
         else count_word = CSR_DATA_W'($urandom_range(1, dims_eff > 8 ? 2 : 6));
         count_eff = clip_size(32'(count_word), MAX_VECTORS);
         case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 3;
            default: gap_odds = 8;
         endcase
         quiesce();
         program_search_size(dims_word, count_word);
         searches = $urandom_range(1, dims_eff > 8 ? 2 : 4);
         repeat (searches)
            stream_search(dims_eff, count_eff, value_mix_type'($urandom_range(0, 2)),
                          $urandom_range(0, 2) == 0 ? 0 : 12);
         // sometimes leave a search unfinished across the next size change
         spare = dims_eff * count_eff;
         if (spare > 1 && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, spare - 1)) offer_element(pick_value(VALUES_WIDE));
         phase_total++;
      end

      req_valid <= 1'b0;
      guard = 0;
      @(posedge clock);
      while (outstanding != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outstanding != 0) $display("%0d expected result beats never arrived", outstanding);
      $display("covered %0d request beats (%0d query loads) over %0d random size settings",
               beats_sent, loads_sent, phase_total);
      $display("%0d searches predicted, incl. a %0d-vector search and a %0d-cycle hold-off",
               searches_done, LONG_VECTORS + 1, HOLD_OFF_CYCLES);
      if (failures == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
